// ----- rtl/table_chain_byte_decompressor_unit_macros.svh -----
// assertion macros for the table chain byte decompressor
`ifndef TABLE_CHAIN_BYTE_DECOMPRESSOR_UNIT_MACROS_SVH
`define TABLE_CHAIN_BYTE_DECOMPRESSOR_UNIT_MACROS_SVH

// same-cycle implication
`define TCBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tcbd_pkg.sv -----
// shared types and constants of the table chain byte decompressor
`timescale 1ns / 1ps
package tcbd_pkg;

  localparam int MAX_ENTRIES_DEF = 255;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int RUN_LIMIT_DEF   = 64;
  localparam int TBL_DEPTH       = 256;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_KEYS   = 3'd1,
    PH_FIRST  = 3'd2,
    PH_SECOND = 3'd3,
    PH_DATA   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_DECIDE     = 14'b00000000000010,
    S_KEY_WR     = 14'b00000000000100,
    S_DATA_EVAL  = 14'b00000000001000,
    S_PUSH_RD    = 14'b00000000010000,
    S_PUSH_WAIT  = 14'b00000000100000,
    S_EXP_HEAD   = 14'b00000001000000,
    S_EXP_EVAL   = 14'b00000010000000,
    S_CHAIN_RD   = 14'b00000100000000,
    S_CHAIN_EVAL = 14'b00001000000000,
    S_POP_WAIT   = 14'b00010000000000,
    S_FINISH     = 14'b00100000000000,
    S_OUT_RD     = 14'b01000000000000,
    S_OUT_LOAD   = 14'b10000000000000
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DECIDE,
    OP_KEY_WR,
    OP_DATA_EVAL,
    OP_PUSH_RD,
    OP_PUSH_WAIT,
    OP_EXP_HEAD,
    OP_EXP_EVAL,
    OP_CHAIN_RD,
    OP_CHAIN_EVAL,
    OP_POP_WAIT,
    OP_FINISH,
    OP_OUT_RD,
    OP_OUT_LOAD
  } op_t;

  typedef enum logic [1:0] {
    DEC_EMIT,
    DEC_PUSH,
    DEC_WALK
  } decision_t;

  typedef struct packed {
    op_t  op;
    logic take;
  } cmd_t;

  typedef struct packed {
    logic      finished;
    logic      func;
    logic      expanding;
    phase_t    phase;
    decision_t dec;
    logic      literal;
    logic      stack_empty;
    logic      room;
    logic      out_free;
    logic      last_out;
  } status_t;

endpackage

// ----- rtl/tcbd_ram.sv -----
// generic ram, one write port and one registered read port
`timescale 1ns / 1ps
module tcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tcbd_datapath.sv -----
// datapath: stream registers, tables, return stack, output buffer and output register
`timescale 1ns / 1ps
module tcbd_datapath #(
  parameter int MAX_ENTRIES = tcbd_pkg::MAX_ENTRIES_DEF,
  parameter int STACK_DEPTH = tcbd_pkg::STACK_DEPTH_DEF,
  parameter int RUN_LIMIT   = tcbd_pkg::RUN_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tcbd_pkg::cmd_t    cmd,
  output tcbd_pkg::status_t status,
  input  logic              func,
  input  logic [7:0]        in_byte,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              has_byte,
  output logic [7:0]        out_byte,
  output logic              run_last,
  output logic              more_pending,
  output logic              stream_done,
  output logic              misuse_error
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int NCW = $clog2(RUN_LIMIT + 1);
  localparam int OAW = (RUN_LIMIT > 1) ? $clog2(RUN_LIMIT) : 1;

  logic                func_q;
  logic [7:0]          byte_q;
  tcbd_pkg::phase_t    phase;
  logic [15:0]         byte_counter;
  logic [7:0]          entry_count;
  logic                final_block;
  logic [15:0]         data_length;
  logic [7:0]          saved_value;
  logic [SCW-1:0]      stack_count;
  logic [7:0]          cur_index;
  logic [7:0]          cur_value;
  logic [7:0]          bound;
  logic [7:0]          idx;
  logic                expanding;
  logic                finished;
  logic                misuse;
  logic [NCW-1:0]      nout;
  logic [NCW-1:0]      k;
  logic [tcbd_pkg::TBL_DEPTH-1:0] head_valid;
  logic                hv_q;

  logic [7:0]  head_rd, chain_rd, first_rd, second_rd, ob_rd;
  logic [15:0] stack_rd;
  logic [7:0]  head_raddr;
  logic        head_we, first_we, second_we, stack_we, ob_we;
  logic [7:0]  ob_wdata;

  logic [7:0]        hd;
  logic [8:0]        ofs;
  logic              store;
  logic [15:0]       cnt_inc;
  logic [SCW-1:0]    stack_dec;
  logic [7:0]        src;
  logic              table_push;
  tcbd_pkg::phase_t  eob_phase;
  tcbd_pkg::phase_t  tbl_phase_next;
  logic [15:0]       tbl_bc_next;
  tcbd_pkg::decision_t dec;
  logic              literal;
  logic              last_out;
  logic              out_free;

  assign hd        = hv_q ? head_rd : 8'd0;
  assign ofs       = {1'b0, byte_counter[7:0]} + 9'd1;
  assign store     = (ofs <= 9'(MAX_ENTRIES));
  assign cnt_inc   = byte_counter + 16'd1;
  assign stack_dec = stack_count - SCW'(1);
  assign src       = (cmd.op == tcbd_pkg::OP_CHAIN_EVAL) ? chain_rd : hd;
  assign literal   = (entry_count == 8'd0) || (hd == 8'd0);
  assign last_out  = ({1'b0, k} + (NCW + 1)'(1)) >= {1'b0, nout};
  assign out_free  = !out_valid || !out_stall;
  assign eob_phase = (entry_count != 8'd0 && final_block) ? tcbd_pkg::PH_DONE
                                                          : tcbd_pkg::PH_HEADER;
  assign table_push = (cmd.op == tcbd_pkg::OP_DECIDE) && !finished && !func_q && !expanding;

  always_comb begin
    tbl_bc_next    = cnt_inc;
    tbl_phase_next = phase;
    if (cnt_inc >= {8'd0, entry_count}) begin
      tbl_bc_next    = 16'd0;
      tbl_phase_next = tcbd_pkg::phase_t'(phase + 3'd1);
      if (tbl_phase_next == tcbd_pkg::PH_DATA && data_length == 16'd0) begin
        tbl_phase_next = eob_phase;
      end
    end
  end

  always_comb begin
    if (cmd.op == tcbd_pkg::OP_CHAIN_EVAL) begin
      if (chain_rd == 8'd0) begin
        dec = tcbd_pkg::DEC_EMIT;
      end else if (chain_rd < bound) begin
        dec = tcbd_pkg::DEC_PUSH;
      end else begin
        dec = tcbd_pkg::DEC_WALK;
      end
    end else begin
      if (hd == 8'd0) begin
        dec = tcbd_pkg::DEC_EMIT;
      end else if (cur_index > hd) begin
        dec = tcbd_pkg::DEC_PUSH;
      end else begin
        dec = tcbd_pkg::DEC_WALK;
      end
    end
  end

  assign head_raddr = (cmd.op == tcbd_pkg::OP_EXP_HEAD) ? cur_value : byte_q;
  assign head_we    = (cmd.op == tcbd_pkg::OP_KEY_WR) && store;
  assign first_we   = table_push && phase == tcbd_pkg::PH_FIRST && store;
  assign second_we  = table_push && phase == tcbd_pkg::PH_SECOND && store;
  assign stack_we   = (cmd.op == tcbd_pkg::OP_PUSH_WAIT) && (stack_count < SCW'(STACK_DEPTH));
  assign ob_we      = ((cmd.op == tcbd_pkg::OP_DATA_EVAL) && literal)
                   || (((cmd.op == tcbd_pkg::OP_EXP_EVAL) || (cmd.op == tcbd_pkg::OP_CHAIN_EVAL))
                       && dec == tcbd_pkg::DEC_EMIT);
  assign ob_wdata   = (cmd.op == tcbd_pkg::OP_DATA_EVAL) ? byte_q : cur_value;

  tcbd_ram #(.WIDTH(8), .DEPTH(tcbd_pkg::TBL_DEPTH)) u_head (
    .clk(clk), .we(head_we), .waddr(byte_q), .wdata(ofs[7:0]),
    .raddr(head_raddr), .rdata(head_rd)
  );

  tcbd_ram #(.WIDTH(8), .DEPTH(tcbd_pkg::TBL_DEPTH)) u_chain (
    .clk(clk), .we(head_we), .waddr(ofs[7:0]), .wdata(hd),
    .raddr(idx), .rdata(chain_rd)
  );

  tcbd_ram #(.WIDTH(8), .DEPTH(tcbd_pkg::TBL_DEPTH)) u_first (
    .clk(clk), .we(first_we), .waddr(ofs[7:0]), .wdata(byte_q),
    .raddr(cur_index), .rdata(first_rd)
  );

  tcbd_ram #(.WIDTH(8), .DEPTH(tcbd_pkg::TBL_DEPTH)) u_second (
    .clk(clk), .we(second_we), .waddr(ofs[7:0]), .wdata(byte_q),
    .raddr(cur_index), .rdata(second_rd)
  );

  tcbd_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stack_we), .waddr(stack_count[SAW-1:0]), .wdata({cur_index, second_rd}),
    .raddr(stack_dec[SAW-1:0]), .rdata(stack_rd)
  );

  tcbd_ram #(.WIDTH(8), .DEPTH(RUN_LIMIT)) u_outbuf (
    .clk(clk), .we(ob_we), .waddr(nout[OAW-1:0]), .wdata(ob_wdata),
    .raddr(k[OAW-1:0]), .rdata(ob_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tcbd_pkg::PH_HEADER;
      byte_counter <= 16'd0;
      entry_count  <= 8'd0;
      final_block  <= 1'b0;
      data_length  <= 16'd0;
      saved_value  <= 8'd0;
      stack_count  <= '0;
      cur_index    <= 8'd0;
      cur_value    <= 8'd0;
      expanding    <= 1'b0;
      finished     <= 1'b0;
      misuse       <= 1'b0;
      nout         <= '0;
      k            <= '0;
      head_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      hv_q <= head_valid[head_raddr];
      if (out_valid && !out_stall && cmd.op != tcbd_pkg::OP_OUT_LOAD) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        tcbd_pkg::OP_IDLE: begin
          if (cmd.take) begin
            func_q <= func;
            byte_q <= in_byte;
            misuse <= 1'b0;
            nout   <= '0;
            k      <= '0;
          end
        end
        tcbd_pkg::OP_DECIDE: begin
          if (finished || (!func_q && expanding)) begin
            misuse <= 1'b1;
          end else if (!func_q) begin
            case (phase)
              tcbd_pkg::PH_HEADER: begin
                if (byte_counter == 16'd0) begin
                  entry_count  <= byte_q;
                  byte_counter <= cnt_inc;
                end else if (byte_counter == 16'd1) begin
                  final_block  <= (byte_q == 8'd0);
                  byte_counter <= cnt_inc;
                end else if (byte_counter == 16'd2) begin
                  saved_value  <= byte_q;
                  byte_counter <= cnt_inc;
                end else begin
                  data_length  <= {byte_q, saved_value};
                  byte_counter <= 16'd0;
                  if (entry_count != 8'd0) begin
                    head_valid <= '0;
                    phase      <= tcbd_pkg::PH_KEYS;
                  end else if ({byte_q, saved_value} != 16'd0) begin
                    phase <= tcbd_pkg::PH_DATA;
                  end else begin
                    phase <= tcbd_pkg::PH_HEADER;
                  end
                end
              end
              tcbd_pkg::PH_FIRST, tcbd_pkg::PH_SECOND: begin
                byte_counter <= tbl_bc_next;
                phase        <= tbl_phase_next;
              end
              default: begin
              end
            endcase
          end
        end
        tcbd_pkg::OP_KEY_WR: begin
          if (store) begin
            head_valid[byte_q] <= 1'b1;
          end
          byte_counter <= tbl_bc_next;
          phase        <= tbl_phase_next;
        end
        tcbd_pkg::OP_DATA_EVAL: begin
          if (cnt_inc >= data_length) begin
            phase        <= eob_phase;
            byte_counter <= 16'd0;
          end else begin
            byte_counter <= cnt_inc;
          end
          if (literal) begin
            nout <= NCW'(1);
          end else begin
            cur_index   <= hd;
            stack_count <= '0;
            expanding   <= 1'b1;
          end
        end
        tcbd_pkg::OP_PUSH_WAIT: begin
          if (stack_count < SCW'(STACK_DEPTH)) begin
            stack_count <= stack_count + SCW'(1);
          end
          cur_value <= first_rd;
        end
        tcbd_pkg::OP_EXP_EVAL, tcbd_pkg::OP_CHAIN_EVAL: begin
          case (dec)
            tcbd_pkg::DEC_EMIT: begin
              nout <= nout + NCW'(1);
              if (stack_count == '0) begin
                expanding <= 1'b0;
              end else begin
                stack_count <= stack_dec;
              end
            end
            tcbd_pkg::DEC_PUSH: begin
              cur_index <= src;
            end
            default: begin
              if (cmd.op == tcbd_pkg::OP_EXP_EVAL) begin
                bound <= cur_index;
              end
              idx <= src;
            end
          endcase
        end
        tcbd_pkg::OP_POP_WAIT: begin
          cur_index <= stack_rd[15:8];
          cur_value <= stack_rd[7:0];
        end
        tcbd_pkg::OP_FINISH: begin
          if (!finished && phase == tcbd_pkg::PH_DONE && !expanding) begin
            finished <= 1'b1;
          end
        end
        tcbd_pkg::OP_OUT_LOAD: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            has_byte     <= (nout != '0);
            out_byte     <= (nout != '0) ? ob_rd : 8'd0;
            run_last     <= last_out;
            more_pending <= expanding;
            stream_done  <= finished;
            misuse_error <= misuse;
            if (!last_out) begin
              k <= k + NCW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status.finished    = finished;
  assign status.func        = func_q;
  assign status.expanding   = expanding;
  assign status.phase       = phase;
  assign status.dec         = dec;
  assign status.literal     = literal;
  assign status.stack_empty = (stack_count == '0);
  assign status.room        = (nout < NCW'(RUN_LIMIT));
  assign status.out_free    = out_free;
  assign status.last_out    = last_out;

endmodule

// ----- rtl/tcbd_controller.sv -----
// controller state machine sequencing parse, descent and result delivery
`timescale 1ns / 1ps
module tcbd_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcbd_pkg::status_t status,
  output tcbd_pkg::cmd_t    cmd
);

  tcbd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcbd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tcbd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = tcbd_pkg::S_DECIDE;
        end
      end
      tcbd_pkg::S_DECIDE: begin
        if (status.finished || (!status.func && status.expanding)) begin
          state_next = tcbd_pkg::S_FINISH;
        end else if (!status.func) begin
          case (status.phase)
            tcbd_pkg::PH_KEYS: state_next = tcbd_pkg::S_KEY_WR;
            tcbd_pkg::PH_DATA: state_next = tcbd_pkg::S_DATA_EVAL;
            default:           state_next = tcbd_pkg::S_FINISH;
          endcase
        end else if (status.expanding) begin
          state_next = tcbd_pkg::S_EXP_HEAD;
        end else begin
          state_next = tcbd_pkg::S_FINISH;
        end
      end
      tcbd_pkg::S_KEY_WR: state_next = tcbd_pkg::S_FINISH;
      tcbd_pkg::S_DATA_EVAL: begin
        state_next = status.literal ? tcbd_pkg::S_FINISH : tcbd_pkg::S_PUSH_RD;
      end
      tcbd_pkg::S_PUSH_RD: state_next = tcbd_pkg::S_PUSH_WAIT;
      tcbd_pkg::S_PUSH_WAIT, tcbd_pkg::S_POP_WAIT: begin
        state_next = status.room ? tcbd_pkg::S_EXP_HEAD : tcbd_pkg::S_FINISH;
      end
      tcbd_pkg::S_EXP_HEAD: state_next = tcbd_pkg::S_EXP_EVAL;
      tcbd_pkg::S_EXP_EVAL, tcbd_pkg::S_CHAIN_EVAL: begin
        case (status.dec)
          tcbd_pkg::DEC_EMIT: begin
            state_next = status.stack_empty ? tcbd_pkg::S_FINISH : tcbd_pkg::S_POP_WAIT;
          end
          tcbd_pkg::DEC_PUSH: state_next = tcbd_pkg::S_PUSH_RD;
          default:            state_next = tcbd_pkg::S_CHAIN_RD;
        endcase
      end
      tcbd_pkg::S_CHAIN_RD: state_next = tcbd_pkg::S_CHAIN_EVAL;
      tcbd_pkg::S_FINISH:   state_next = tcbd_pkg::S_OUT_RD;
      tcbd_pkg::S_OUT_RD:   state_next = tcbd_pkg::S_OUT_LOAD;
      tcbd_pkg::S_OUT_LOAD: begin
        if (status.out_free) begin
          state_next = status.last_out ? tcbd_pkg::S_IDLE : tcbd_pkg::S_OUT_RD;
        end
      end
      default: state_next = tcbd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.take = (state == tcbd_pkg::S_IDLE) && in_valid;
    case (state)
      tcbd_pkg::S_IDLE:       cmd.op = tcbd_pkg::OP_IDLE;
      tcbd_pkg::S_DECIDE:     cmd.op = tcbd_pkg::OP_DECIDE;
      tcbd_pkg::S_KEY_WR:     cmd.op = tcbd_pkg::OP_KEY_WR;
      tcbd_pkg::S_DATA_EVAL:  cmd.op = tcbd_pkg::OP_DATA_EVAL;
      tcbd_pkg::S_PUSH_RD:    cmd.op = tcbd_pkg::OP_PUSH_RD;
      tcbd_pkg::S_PUSH_WAIT:  cmd.op = tcbd_pkg::OP_PUSH_WAIT;
      tcbd_pkg::S_EXP_HEAD:   cmd.op = tcbd_pkg::OP_EXP_HEAD;
      tcbd_pkg::S_EXP_EVAL:   cmd.op = tcbd_pkg::OP_EXP_EVAL;
      tcbd_pkg::S_CHAIN_RD:   cmd.op = tcbd_pkg::OP_CHAIN_RD;
      tcbd_pkg::S_CHAIN_EVAL: cmd.op = tcbd_pkg::OP_CHAIN_EVAL;
      tcbd_pkg::S_POP_WAIT:   cmd.op = tcbd_pkg::OP_POP_WAIT;
      tcbd_pkg::S_FINISH:     cmd.op = tcbd_pkg::OP_FINISH;
      tcbd_pkg::S_OUT_RD:     cmd.op = tcbd_pkg::OP_OUT_RD;
      tcbd_pkg::S_OUT_LOAD:   cmd.op = tcbd_pkg::OP_OUT_LOAD;
      default:                cmd.op = tcbd_pkg::OP_IDLE;
    endcase
  end

  assign in_stall = (state != tcbd_pkg::S_IDLE);

endmodule

// ----- rtl/table_chain_byte_decompressor_unit.sv -----
// top level of the table chain byte decompressor
`timescale 1ns / 1ps
// One request at a time: a header, first or second table byte goes through the
// decide, finish and output states, a key byte adds a key write state and a
// literal data byte a data evaluation state; a coded byte adds a head read and
// evaluation per head lookup, a chain read and evaluation per chain link walked,
// a push read and wait per stack push and a pop wait per stack pop, since the
// table and stack memories have registered reads. Results leave from an output
// buffer through the output register, and the last result may still wait there
// while the next request is taken. The head table's valid bits, one per entry,
// are cleared at once by a table block's fourth header byte: no clearing pass.
module table_chain_byte_decompressor_unit #(
  parameter int MAX_ENTRIES = tcbd_pkg::MAX_ENTRIES_DEF,
  parameter int STACK_DEPTH = tcbd_pkg::STACK_DEPTH_DEF,
  parameter int RUN_LIMIT   = tcbd_pkg::RUN_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       has_byte,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       more_pending,
  output logic       stream_done,
  output logic       misuse_error
);

  tcbd_pkg::cmd_t    cmd;
  tcbd_pkg::status_t status;

  tcbd_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd)
  );

  tcbd_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES), .STACK_DEPTH(STACK_DEPTH), .RUN_LIMIT(RUN_LIMIT)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .func(func), .in_byte(in_byte), .out_stall(out_stall), .out_valid(out_valid),
    .has_byte(has_byte), .out_byte(out_byte), .run_last(run_last),
    .more_pending(more_pending), .stream_done(stream_done), .misuse_error(misuse_error)
  );

endmodule

// ----- rtl/tcbd_checker.sv -----
// port checker for the table chain byte decompressor, bound to the top level
`timescale 1ns / 1ps
`include "table_chain_byte_decompressor_unit_macros.svh"
module tcbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       func,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       has_byte,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       misuse_error
);

  `TCBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte), "stalled result changed")
  `TCBD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_byte) && $stable(func), "stalled request changed")
  `TCBD_ASSERT_NOW(a_empty_last, out_valid && !has_byte, run_last && out_byte == 8'd0, "empty result not last")
  `TCBD_ASSERT_NOW(a_misuse_empty, out_valid && misuse_error, !has_byte && run_last, "misuse result carries byte")

endmodule

bind table_chain_byte_decompressor_unit tcbd_checker u_tcbd_checker (.*);
